### design/nsr_pkg.sv
package nsr_pkg;

    localparam int RADICAND_W = 32;
    localparam int GUESS_W    = 48;
    localparam int QUOT_W     = 64;
    localparam int STEPS_W    = 7;
    localparam int PC_W       = 4;

    // change test: |new - old| * CONV_SCALE <= new
    localparam int CONV_SCALE_W = 17;
    localparam logic [CONV_SCALE_W-1:0] CONV_SCALE = 17'd100000;

    localparam logic [GUESS_W-1:0] GUESS_MAX = {GUESS_W{1'b1}};
    localparam logic [QUOT_W-1:0]  QUOT_CAP  = {1'b1, {(QUOT_W-1){1'b0}}};

    // datapath operation selected by the current microcode word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_DIFF,
        OP_MULT,
        OP_TEST,
        OP_EMIT
    } t_op;

    // status seen by the sequencer's jump conditions
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic x_zero;
        logic div_busy;
        logic converged;
        logic at_limit;
    } t_flags;

endpackage

### design/nsr_seq.sv
module nsr_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nsr_pkg::t_flags i_flags,
    output nsr_pkg::t_op   o_op
);

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_X_ZERO,
        C_DIV_BUSY,
        C_CONTINUE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        nsr_pkg::t_op             op;
        t_cond                    cond;
        logic [nsr_pkg::PC_W-1:0] target;
    } t_uword;

    localparam logic [nsr_pkg::PC_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [nsr_pkg::PC_W-1:0] ST_DIV_INIT = 4'd1;
    localparam logic [nsr_pkg::PC_W-1:0] ST_DIV_STEP = 4'd2;
    localparam logic [nsr_pkg::PC_W-1:0] ST_UPDATE   = 4'd3;
    localparam logic [nsr_pkg::PC_W-1:0] ST_DIFF     = 4'd4;
    localparam logic [nsr_pkg::PC_W-1:0] ST_MULT     = 4'd5;
    localparam logic [nsr_pkg::PC_W-1:0] ST_TEST     = 4'd6;
    localparam logic [nsr_pkg::PC_W-1:0] ST_EMIT     = 4'd7;
    localparam logic [nsr_pkg::PC_W-1:0] ST_RETURN   = 4'd8;

    function automatic t_uword rom(input logic [nsr_pkg::PC_W-1:0] addr);
        t_uword w;
        case (addr)
            ST_WAIT:     w = '{nsr_pkg::OP_ACCEPT,   C_NO_INPUT, ST_WAIT};
            ST_DIV_INIT: w = '{nsr_pkg::OP_DIV_INIT, C_X_ZERO,   ST_EMIT};
            ST_DIV_STEP: w = '{nsr_pkg::OP_DIV_STEP, C_DIV_BUSY, ST_DIV_STEP};
            ST_UPDATE:   w = '{nsr_pkg::OP_UPDATE,   C_NEXT,     ST_WAIT};
            ST_DIFF:     w = '{nsr_pkg::OP_DIFF,     C_NEXT,     ST_WAIT};
            ST_MULT:     w = '{nsr_pkg::OP_MULT,     C_NEXT,     ST_WAIT};
            ST_TEST:     w = '{nsr_pkg::OP_TEST,     C_CONTINUE, ST_DIV_INIT};
            ST_EMIT:     w = '{nsr_pkg::OP_EMIT,     C_OUT_BUSY, ST_EMIT};
            ST_RETURN:   w = '{nsr_pkg::OP_NOP,      C_ALWAYS,   ST_WAIT};
            default:     w = '{nsr_pkg::OP_NOP,      C_ALWAYS,   ST_WAIT};
        endcase
        return w;
    endfunction

    logic [nsr_pkg::PC_W-1:0] r_pc;
    logic [nsr_pkg::PC_W-1:0] n_pc;
    t_uword                   w_word;
    logic                     w_jump;

    always_comb begin
        w_word = rom(r_pc);
        case (w_word.cond)
            C_NEXT:     w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_NO_INPUT: w_jump = !i_flags.in_valid;
            C_X_ZERO:   w_jump = i_flags.x_zero;
            C_DIV_BUSY: w_jump = i_flags.div_busy;
            C_CONTINUE: w_jump = !i_flags.converged && !i_flags.at_limit;
            C_OUT_BUSY: w_jump = i_flags.out_busy;
            default:    w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_word.target : r_pc + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = w_word.op;

`ifndef SYNTH
    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= ST_RETURN)
        else $error("sequencer left the program");
    a_step_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_DIV_STEP && !i_flags.div_busy) |=> r_pc == ST_UPDATE)
        else $error("division did not hand over to update");
    a_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ST_WAIT && !i_flags.in_valid) |=> r_pc == ST_WAIT)
        else $error("left wait without an item");
`endif

endmodule

### design/nsr_datapath.sv
module nsr_datapath #(
    parameter int MAX_STEPS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nsr_pkg::t_op                      i_op,
    input  logic                              i_in_valid,
    input  logic [nsr_pkg::RADICAND_W-1:0]    i_radicand,
    output logic                              o_x_zero,
    output logic                              o_div_busy,
    output logic                              o_converged,
    output logic                              o_at_limit,
    output logic [31:0]                       o_root,
    output logic [nsr_pkg::GUESS_W-1:0]       o_last_quotient,
    output logic [nsr_pkg::STEPS_W-1:0]       o_steps_taken,
    output logic                              o_limit_hit
);

    localparam int DIV_BITS = nsr_pkg::RADICAND_W + 2 * FRACTION_BITS;
    localparam int CNT_W    = $clog2(DIV_BITS);
    localparam int GW       = nsr_pkg::GUESS_W;
    localparam int QW       = nsr_pkg::QUOT_W;
    localparam int PW       = GW + nsr_pkg::CONV_SCALE_W;
    localparam logic [GW-1:0] ONE = GW'(1) << FRACTION_BITS;

    logic [nsr_pkg::RADICAND_W-1:0] r_x;
    logic [nsr_pkg::RADICAND_W-1:0] r_dsh;
    logic [GW-1:0]                  r_guess;
    logic [GW-1:0]                  r_prev;
    logic [GW-1:0]                  r_rem;
    logic [QW-1:0]                  r_q;
    logic                           r_sat;
    logic [CNT_W-1:0]               r_cnt;
    logic [GW-1:0]                  r_diff;
    logic [PW-1:0]                  r_prod;
    logic [GW-1:0]                  r_quot;
    logic [nsr_pkg::STEPS_W-1:0]    r_n;
    logic                           r_limit;

    logic [GW-1:0] w_div;
    logic [GW:0]   w_rem_sh;
    logic [GW:0]   w_rem_sub;
    logic          w_rem_ge;
    logic [QW-1:0] w_q_sat;
    logic [QW-1:0] w_sum;
    logic [GW-1:0] w_ng;
    logic [GW-1:0] w_diff;
    logic [GW-1:0] w_quot_out;

    always_comb begin
        w_div     = (r_guess == '0) ? GW'(1) : r_guess;
        w_rem_sh  = {r_rem, r_dsh[nsr_pkg::RADICAND_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, w_div};
        w_rem_ge  = w_rem_sh >= {1'b0, w_div};
        w_q_sat   = (r_sat || r_q > nsr_pkg::QUOT_CAP) ? nsr_pkg::QUOT_CAP : r_q;
        w_sum     = {{(QW-GW){1'b0}}, r_guess} + w_q_sat;
        w_ng      = (w_sum[QW-1:1] > (QW-1)'(nsr_pkg::GUESS_MAX)) ?
                    nsr_pkg::GUESS_MAX : w_sum[GW:1];
        w_diff    = (r_guess >= r_prev) ? r_guess - r_prev : r_prev - r_guess;
        w_quot_out = (w_q_sat > QW'(nsr_pkg::GUESS_MAX)) ?
                     nsr_pkg::GUESS_MAX : w_q_sat[GW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_limit <= 1'b0;
            r_guess <= ONE;
        end else begin
            case (i_op)
                nsr_pkg::OP_ACCEPT: begin
                    if (i_in_valid) begin
                        r_x     <= i_radicand;
                        r_guess <= (i_radicand == '0) ? '0 : ONE;
                        r_n     <= '0;
                        r_limit <= 1'b0;
                        r_quot  <= '0;
                    end
                end
                nsr_pkg::OP_DIV_INIT: begin
                    r_dsh <= r_x;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_sat <= 1'b0;
                    r_cnt <= CNT_W'(DIV_BITS - 1);
                end
                nsr_pkg::OP_DIV_STEP: begin
                    // radicand bits come first, then the zeros of the scaling
                    r_dsh <= r_dsh << 1;
                    r_rem <= w_rem_ge ? w_rem_sub[GW-1:0] : w_rem_sh[GW-1:0];
                    r_sat <= r_sat | r_q[QW-1];
                    r_q   <= {r_q[QW-2:0], w_rem_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                nsr_pkg::OP_UPDATE: begin
                    r_prev  <= r_guess;
                    r_guess <= w_ng;
                    r_quot  <= w_quot_out;
                    r_n     <= r_n + nsr_pkg::STEPS_W'(1);
                end
                nsr_pkg::OP_DIFF: begin
                    r_diff <= w_diff;
                end
                nsr_pkg::OP_MULT: begin
                    r_prod <= PW'(r_diff) * PW'(nsr_pkg::CONV_SCALE);
                end
                nsr_pkg::OP_TEST: begin
                    r_limit <= !o_converged && o_at_limit;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_x_zero    = (r_x == '0);
    assign o_div_busy  = (r_cnt != '0);
    assign o_converged = (r_diff <= GW'(1)) || (r_prod <= PW'(r_guess));
    assign o_at_limit  = (r_n >= nsr_pkg::STEPS_W'(MAX_STEPS));

    assign o_root          = (r_guess[GW-1:32] != '0) ? 32'hFFFF_FFFF : r_guess[31:0];
    assign o_last_quotient = r_quot;
    assign o_steps_taken   = r_n;
    assign o_limit_hit     = r_limit;

endmodule

### design/newton_square_root.sv
// Square root of a 32-bit unsigned radicand by Newton iteration, returned as
// unsigned fixed point with FRACTION_BITS fraction bits, one result item per
// input item. A small microcode program steps a shared datapath; each Newton
// step runs a restoring divider at one quotient bit a cycle, and an item takes up to
// MAX_STEPS steps. A zero radicand skips the iteration.
// One item is worked on at a time; the next item can be taken once the sequencer has
// passed its return state after the finished result is loaded into the output
// register, even if it is not yet taken.
module newton_square_root #(
    parameter int MAX_STEPS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // radicand[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata    // root[31:0], last_quotient[79:32],
                                          // steps_taken[86:80], limit_hit[87]
);

    nsr_pkg::t_op    w_op;
    nsr_pkg::t_flags w_flags;

    logic                          w_x_zero;
    logic                          w_div_busy;
    logic                          w_converged;
    logic                          w_at_limit;
    logic [31:0]                   w_root;
    logic [nsr_pkg::GUESS_W-1:0]   w_last_quotient;
    logic [nsr_pkg::STEPS_W-1:0]   w_steps_taken;
    logic                          w_limit_hit;
    logic                          w_out_busy;
    logic                          w_load;

    logic        r_out_valid;
    logic [87:0] r_out_data;

    assign w_out_busy = r_out_valid && !i_m_axis_tready;
    assign w_load     = (w_op == nsr_pkg::OP_EMIT) && !w_out_busy;

    assign w_flags = '{
        in_valid:  i_s_axis_tvalid,
        out_busy:  w_out_busy,
        x_zero:    w_x_zero,
        div_busy:  w_div_busy,
        converged: w_converged,
        at_limit:  w_at_limit
    };

    nsr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_op    (w_op)
    );

    nsr_datapath #(
        .MAX_STEPS     (MAX_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .i_in_valid      (i_s_axis_tvalid),
        .i_radicand      (i_s_axis_tdata),
        .o_x_zero        (w_x_zero),
        .o_div_busy      (w_div_busy),
        .o_converged     (w_converged),
        .o_at_limit      (w_at_limit),
        .o_root          (w_root),
        .o_last_quotient (w_last_quotient),
        .o_steps_taken   (w_steps_taken),
        .o_limit_hit     (w_limit_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {w_limit_hit, w_steps_taken, w_last_quotient, w_root};
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_axis_tready = (w_op == nsr_pkg::OP_ACCEPT);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[87]) |-> r_out_data[86:80] == 7'(MAX_STEPS))
        else $error("limit flag without a full step count");
    a_zero_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[86:80] == '0) |-> r_out_data[79:0] == '0)
        else $error("zero steps but a nonzero result");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !w_out_busy)
        else $error("result written over one not yet taken");
    a_accept_not_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !w_load)
        else $error("result emitted right after an item was taken");
`endif

endmodule
